/* sv/assert_macros.svh */
// ------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is defined
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// antecedent implies consequent on the same edge
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rst, cond)

`endif

`endif

/* sv/sfl_pkg.sv */
// ------------------------------------------------------------------------
// sfl_pkg
// shared types, register map and codes for the safety fault latch
// ------------------------------------------------------------------------
`default_nettype none

package sfl_pkg;

  // internal time arithmetic width
  localparam int TIME_BITS = 32;
  typedef logic [TIME_BITS-1:0] time_t;

  // register map, index is paddr[3:2]
  localparam logic [1:0] REG_MAX_AGE    = 2'd0;
  localparam logic [1:0] REG_NEUTRAL    = 2'd1;
  localparam logic [1:0] REG_CLEAR_HOLD = 2'd2;
  localparam logic [1:0] REG_PROFILE    = 2'd3;

  // register reset values
  localparam logic [15:0] MAX_AGE_RST    = 16'd200;
  localparam logic [9:0]  NEUTRAL_RST    = 10'd100;
  localparam logic [15:0] CLEAR_HOLD_RST = 16'd2000;

  // fixture profiles
  localparam logic [1:0] PROFILE_JOYSTICK = 2'd0;
  localparam logic [1:0] PROFILE_TOUCH    = 2'd1;
  localparam logic [1:0] PROFILE_COMBINED = 2'd2;

  // fault codes
  localparam logic [1:0] FAULT_NONE        = 2'd0;
  localparam logic [1:0] FAULT_UNAVAILABLE = 2'd1;
  localparam logic [1:0] FAULT_STALE       = 2'd2;
  localparam logic [1:0] FAULT_TOUCH       = 2'd3;

  // one captured input snapshot
  typedef struct packed {
    logic [31:0]        sequence_number;
    time_t              captured_time;
    time_t              current_time;
    logic               input_valid;
    logic               stick_present;
    logic signed [10:0] stick_x;
    logic signed [10:0] stick_y;
    logic               touch_on;
    logic               service_button;
  } snap_t;

  // magnitude of a signed permille axis value
  function automatic logic [10:0] axis_mag(input logic signed [10:0] v);
    logic [10:0] neg;
    neg = 11'(-v);
    return v[10] ? neg : v;
  endfunction

endpackage

`default_nettype wire

/* sv/safety_fault_latch.sv */
// ------------------------------------------------------------------------
// safety_fault_latch
// pipeline: an input beat passes the input reg, then the result reg, to the result beat
// throughput: one beat per cycle while out_ready allows, state updates as each result is formed
// reset: sync active high; config and state registers return to defaults, no fault latched
// ------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module safety_fault_latch (
  input  wire logic               clk,
  input  wire logic               rst,
  // apb config port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [31:0]        sequence_number,
  input  wire logic [31:0]        captured_time,
  input  wire logic [31:0]        current_time,
  input  wire logic               input_valid,
  input  wire logic               stick_present,
  input  wire logic signed [10:0] stick_x,
  input  wire logic signed [10:0] stick_y,
  input  wire logic               touch_on,
  input  wire logic               service_button,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [31:0]        snap_sequence,
  output logic      [31:0]        update_time,
  output logic                    snap_fresh,
  output logic                    fault_active,
  output logic      [1:0]         fault_code,
  output logic      [15:0]        hold_progress_ms,
  output logic                    clear_event,
  output logic                    manual_request
);

  // config registers
  logic [15:0] max_input_age_ms;
  logic [9:0]  neutral_limit;
  logic [15:0] clear_hold_time_ms;
  logic [1:0]  fixture_profile;

  // latch and handshake state
  logic              fault_flag, fault_flag_next;
  logic [1:0]        fault_reason, fault_reason_next;
  logic              release_armed, release_armed_next;
  logic              press_start_valid, press_start_valid_next;
  sfl_pkg::time_t    press_start_time, press_start_time_next;
  logic [15:0]       hold_elapsed, hold_elapsed_next;
  logic              cleared;

  // input stage
  logic           s1_valid;
  sfl_pkg::snap_t snap;
  logic           out_load;
  logic           s1_fire;

  // datapath terms
  sfl_pkg::time_t age;
  logic           fresh_time;
  logic           fresh;
  logic           neutral;
  logic           demand;
  logic           combined;
  logic           safe;
  logic [1:0]     raise_code;
  sfl_pkg::time_t start_eff;
  sfl_pkg::time_t elapsed;
  logic           late;
  logic           reached;

  // apb write strobe
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_input_age_ms   <= sfl_pkg::MAX_AGE_RST;
      neutral_limit      <= sfl_pkg::NEUTRAL_RST;
      clear_hold_time_ms <= sfl_pkg::CLEAR_HOLD_RST;
      fixture_profile    <= sfl_pkg::PROFILE_JOYSTICK;
    end else if (cfg_we) begin
      case (paddr[3:2])
        sfl_pkg::REG_MAX_AGE:    max_input_age_ms   <= pwdata[15:0];
        sfl_pkg::REG_NEUTRAL:    neutral_limit      <= pwdata[9:0];
        sfl_pkg::REG_CLEAR_HOLD: clear_hold_time_ms <= pwdata[15:0];
        sfl_pkg::REG_PROFILE:    fixture_profile    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // config readback
  always_comb begin
    case (paddr[3:2])
      sfl_pkg::REG_MAX_AGE:    prdata = {16'd0, max_input_age_ms};
      sfl_pkg::REG_NEUTRAL:    prdata = {22'd0, neutral_limit};
      sfl_pkg::REG_CLEAR_HOLD: prdata = {16'd0, clear_hold_time_ms};
      sfl_pkg::REG_PROFILE:    prdata = {30'd0, fixture_profile};
      default:                 prdata = 32'd0;
    endcase
  end

  // pipeline flow control
  assign out_load = ~out_valid | out_ready;
  assign s1_fire  = s1_valid & out_load;
  assign in_ready = ~s1_valid | out_load;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid & in_ready) begin
      snap.sequence_number <= sequence_number;
      snap.captured_time   <= sfl_pkg::time_t'(captured_time);
      snap.current_time    <= sfl_pkg::time_t'(current_time);
      snap.input_valid     <= input_valid;
      snap.stick_present   <= stick_present;
      snap.stick_x         <= stick_x;
      snap.stick_y         <= stick_y;
      snap.touch_on        <= touch_on;
      snap.service_button  <= service_button;
    end
  end

  // freshness and stick checks
  assign age        = snap.current_time - snap.captured_time;
  assign fresh_time = (snap.current_time >= snap.captured_time) &&
                      (age <= sfl_pkg::time_t'(max_input_age_ms));
  assign fresh      = snap.input_valid & fresh_time;
  assign neutral    = (sfl_pkg::axis_mag(snap.stick_x) <= {1'b0, neutral_limit}) &&
                      (sfl_pkg::axis_mag(snap.stick_y) <= {1'b0, neutral_limit});
  assign combined   = (fixture_profile == sfl_pkg::PROFILE_COMBINED);
  assign demand     = (fixture_profile == sfl_pkg::PROFILE_TOUCH) ? snap.touch_on :
                      (snap.stick_present & ~neutral);
  assign safe       = combined & fresh & ~snap.touch_on & neutral;

  // fault priority: unavailable, stale, touch in combined profile
  always_comb begin
    if (!snap.input_valid) begin
      raise_code = sfl_pkg::FAULT_UNAVAILABLE;
    end else if (!fresh_time) begin
      raise_code = sfl_pkg::FAULT_STALE;
    end else if (combined && snap.touch_on) begin
      raise_code = sfl_pkg::FAULT_TOUCH;
    end else begin
      raise_code = sfl_pkg::FAULT_NONE;
    end
  end

  // hold timing against the recorded press start
  assign start_eff = press_start_valid ? press_start_time : snap.current_time;
  assign late      = snap.current_time < start_eff;
  assign elapsed   = snap.current_time - start_eff;
  assign reached   = elapsed >= sfl_pkg::time_t'(clear_hold_time_ms);

  // latch and clear handshake
  always_comb begin
    fault_flag_next        = fault_flag;
    fault_reason_next      = fault_reason;
    release_armed_next     = release_armed;
    press_start_valid_next = press_start_valid;
    press_start_time_next  = press_start_time;
    hold_elapsed_next      = hold_elapsed;
    cleared                = 1'b0;

    if (raise_code != sfl_pkg::FAULT_NONE) begin
      fault_flag_next   = 1'b1;
      fault_reason_next = raise_code;
    end

    if (fault_flag_next) begin
      if (!safe) begin
        release_armed_next     = 1'b0;
        press_start_valid_next = 1'b0;
        press_start_time_next  = '0;
        hold_elapsed_next      = '0;
      end else if (!snap.service_button) begin
        release_armed_next     = 1'b1;
        press_start_valid_next = 1'b0;
        press_start_time_next  = '0;
        hold_elapsed_next      = '0;
      end else if (release_armed) begin
        press_start_valid_next = 1'b1;
        press_start_time_next  = start_eff;
        if (late) begin
          release_armed_next     = 1'b0;
          press_start_valid_next = 1'b0;
          press_start_time_next  = '0;
          hold_elapsed_next      = '0;
        end else if (reached) begin
          fault_flag_next        = 1'b0;
          fault_reason_next      = sfl_pkg::FAULT_NONE;
          release_armed_next     = 1'b0;
          press_start_valid_next = 1'b0;
          press_start_time_next  = '0;
          hold_elapsed_next      = '0;
          cleared                = 1'b1;
        end else begin
          hold_elapsed_next = elapsed[15:0];
        end
      end
    end
  end

  // state update, one step per beat leaving the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      fault_flag        <= 1'b0;
      fault_reason      <= sfl_pkg::FAULT_NONE;
      release_armed     <= 1'b0;
      press_start_valid <= 1'b0;
      press_start_time  <= '0;
      hold_elapsed      <= '0;
    end else if (s1_fire) begin
      fault_flag        <= fault_flag_next;
      fault_reason      <= fault_reason_next;
      release_armed     <= release_armed_next;
      press_start_valid <= press_start_valid_next;
      press_start_time  <= press_start_time_next;
      hold_elapsed      <= hold_elapsed_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      snap_sequence    <= snap.sequence_number;
      update_time      <= 32'(snap.current_time);
      snap_fresh       <= fresh;
      fault_active     <= fault_flag_next;
      fault_code       <= fault_reason_next;
      hold_progress_ms <= hold_elapsed_next;
      clear_event      <= cleared;
      manual_request   <= fresh & ~fault_flag_next & demand;
    end
  end

  // checks
  `ASSERT_ALWAYS(a_flag_reason, clk, rst, fault_flag == (fault_reason != sfl_pkg::FAULT_NONE))
  `ASSERT_IMPLY(a_out_code, clk, rst, out_valid, fault_active == (fault_code != sfl_pkg::FAULT_NONE))
  `ASSERT_IMPLY(a_clear_out, clk, rst, out_valid && clear_event, !fault_active && snap_fresh)
  `ASSERT_IMPLY(a_manual, clk, rst, out_valid && manual_request, snap_fresh && !fault_active)
  `ASSERT_IMPLY(a_hold_cap, clk, rst, out_valid, hold_progress_ms <= clear_hold_time_ms)

endmodule

`default_nettype wire
